FILE: sv/ennc_pkg.sv
// shared types and constants for the euler number counter
`timescale 1ns / 1ps

package ennc_pkg;

  localparam int unsigned LABEL_W = 16;
  localparam int unsigned COLS_W  = 11;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CNT_W   = 21;
  localparam int unsigned EUL_W   = 22;
  localparam int unsigned OUT_W   = 64;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // configuration register indexes
  localparam logic CFG_TARGET_LABEL = 1'b0;
  localparam logic CFG_FRAME_COLS   = 1'b1;

  localparam logic [LABEL_W-1:0] TARGET_RST = 16'd1;
  localparam logic [COLS_W-1:0]  COLS_RST   = 11'd1024;

  // control carried from the read stage into the corner stage
  typedef struct packed {
    logic valid;
    logic match;
    logic first_row;
    logic col_zero;
    logic last;
  } s2_ctl_t;

endpackage

FILE: sv/euler_number_counter.sv
// top level: euler number of one labeled object over a raster pixel stream
`timescale 1ns / 1ps

// Takes one label per cycle in raster order and counts convex and concave
// 2x2 corner patterns of the pixels equal to target_label; the first row and
// first column of a frame never count. On the pixel marked by in_tlast one
// result leaves with the convex count, the concave count and their
// difference, and the frame state clears. Each pixel goes through two
// stages: the first reads the previous row's match bit from the line store
// (a registered read), the second tests the corner, updates the
// counters and writes the pixel's own match bit back. A pixel is taken every
// cycle; in_tready drops only while a finished frame result is still held in
// the output register and the next frame-end pixel waits behind it. Counters
// saturate at 2^21-1. Row width is frame_cols clamped to 2..MAX_COLS;
// configuration must be written only between frames; the block does not enforce it.

module euler_number_counter #(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned LABEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ennc_pkg::LABEL_W-1:0]  in_tdata,   // pixel_label
  input  logic                          in_tlast,   // frame_end
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ennc_pkg::OUT_W-1:0]    out_tdata,  // convex_count, concave_count, euler_value
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [ennc_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int unsigned COL_W   = $clog2(MAX_COLS);
  localparam int unsigned WID_W   = COL_W + 1;
  localparam int unsigned CMP_W   = (WID_W > ennc_pkg::COLS_W) ? WID_W : ennc_pkg::COLS_W;
  localparam int unsigned MATCH_W = (LABEL_BITS < ennc_pkg::LABEL_W) ? LABEL_BITS
                                                                     : ennc_pkg::LABEL_W;
  localparam logic [CMP_W-1:0] MAX_COLS_C = CMP_W'(MAX_COLS);
  localparam logic [CMP_W-1:0] MIN_COLS_C = CMP_W'(2);

  logic [ennc_pkg::LABEL_W-1:0] target_r;
  logic [ennc_pkg::COLS_W-1:0]  cols_r;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic              first_row_r, first_row_nxt;
  logic [CMP_W-1:0]  width_c;
  logic [CMP_W-1:0]  col_inc;
  logic              row_done;

  ennc_pkg::s2_ctl_t s2_r, s2_nxt;
  logic [COL_W-1:0]  s2_col_r;
  logic              s2_hold, s2_adv;
  logic              in_acc;
  logic              up_raw;
  logic              match;

  logic [ennc_pkg::CNT_W-1:0] convex_nxt, concave_nxt;
  logic [ennc_pkg::EUL_W-1:0] euler_c;
  logic                       out_valid_r;
  logic [ennc_pkg::OUT_W-1:0] out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= ennc_pkg::TARGET_RST;
      cols_r   <= ennc_pkg::COLS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        ennc_pkg::CFG_TARGET_LABEL: target_r <= cfg_wdata;
        ennc_pkg::CFG_FRAME_COLS:   cols_r   <= cfg_wdata[ennc_pkg::COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_c = CMP_W'(cols_r);
    if (width_c < MIN_COLS_C) begin
      width_c = MIN_COLS_C;
    end else if (width_c > MAX_COLS_C) begin
      width_c = MAX_COLS_C;
    end
  end

  assign s2_hold   = s2_r.valid & s2_r.last & out_valid_r & ~out_tready;
  assign s2_adv    = s2_r.valid & ~s2_hold;
  assign in_tready = ~s2_hold;
  assign in_acc    = in_tvalid & in_tready;

  assign match   = (in_tdata[MATCH_W-1:0] == target_r[MATCH_W-1:0]);
  assign col_inc = CMP_W'(col_r) + 1'b1;
  assign row_done = (col_inc >= width_c);

  // read stage: column walk and line store read
  always_comb begin
    col_nxt       = col_r;
    first_row_nxt = first_row_r;
    if (in_tlast) begin
      col_nxt       = '0;
      first_row_nxt = 1'b1;
    end else if (row_done) begin
      col_nxt       = '0;
      first_row_nxt = 1'b0;
    end else begin
      col_nxt = col_inc[COL_W-1:0];
    end
    s2_nxt.valid     = in_acc;
    s2_nxt.match     = match;
    s2_nxt.first_row = first_row_r;
    s2_nxt.col_zero  = (col_r == '0);
    s2_nxt.last      = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_row_r <= 1'b1;
      s2_r        <= '0;
    end else begin
      if (in_acc) begin
        col_r       <= col_nxt;
        first_row_r <= first_row_nxt;
      end
      if (in_tready) begin
        s2_r <= s2_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_col_r <= col_r;
    end
  end

  ennc_line_mem #(
    .MAX_COLS (MAX_COLS),
    .ADDR_W   (COL_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (up_raw),
    .wr_en   (s2_adv),
    .wr_addr (s2_col_r),
    .wr_data (s2_r.match)
  );

  ennc_corner u_corner (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (s2_r),
    .advance     (s2_adv),
    .up_raw      (up_raw),
    .convex_nxt  (convex_nxt),
    .concave_nxt (concave_nxt)
  );

  assign euler_c = {1'b0, convex_nxt} - {1'b0, concave_nxt};

  // result register, one transfer per frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv && s2_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_r.last) begin
      out_data_r <= {euler_c, concave_nxt, convex_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: sv/ennc_line_mem.sv
// one-bit line store of the previous row's matches, with a registered read
`timescale 1ns / 1ps

module ennc_line_mem #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned ADDR_W   = $clog2(MAX_COLS)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_data
);

  logic mem [MAX_COLS];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/ennc_corner.sv
// corner test, neighbor bits and saturating corner counters
`timescale 1ns / 1ps

module ennc_corner (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ennc_pkg::s2_ctl_t         ctl,
  input  logic                      advance,
  input  logic                      up_raw,
  output logic [ennc_pkg::CNT_W-1:0] convex_nxt,
  output logic [ennc_pkg::CNT_W-1:0] concave_nxt
);

  logic                       ul_r, ul_nxt;
  logic                       left_r, left_nxt;
  logic [ennc_pkg::CNT_W-1:0] convex_r, concave_r;
  logic                       up;
  logic                       hit;
  logic                       convex_hit, concave_hit;

  assign up  = ctl.first_row ? 1'b0 : up_raw;
  assign hit = ctl.match & ~ctl.first_row & ~ctl.col_zero & ~ul_r;
  assign convex_hit  = hit & ~up & ~left_r;
  assign concave_hit = hit & up & left_r;

  // counts including this pixel, saturating
  always_comb begin
    convex_nxt  = convex_r;
    concave_nxt = concave_r;
    if (convex_hit && convex_r != ennc_pkg::CNT_MAX) begin
      convex_nxt = convex_r + 1'b1;
    end
    if (concave_hit && concave_r != ennc_pkg::CNT_MAX) begin
      concave_nxt = concave_r + 1'b1;
    end
    ul_nxt   = up;
    left_nxt = ctl.match;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ul_r      <= 1'b0;
      left_r    <= 1'b0;
      convex_r  <= '0;
      concave_r <= '0;
    end else if (advance) begin
      if (ctl.last) begin
        // frame done, start the next one clean
        ul_r      <= 1'b0;
        left_r    <= 1'b0;
        convex_r  <= '0;
        concave_r <= '0;
      end else begin
        ul_r      <= ul_nxt;
        left_r    <= left_nxt;
        convex_r  <= convex_nxt;
        concave_r <= concave_nxt;
      end
    end
  end

endmodule

FILE: tb/euler_number_counter_checker.sv
// result checker for the euler number counter: predicts corner counts per frame and compares
`timescale 1ns / 1ps

module euler_number_counter_checker #(
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [ennc_pkg::LABEL_W-1:0]  in_tdata,   // pixel_label
  input  logic                          in_tlast,   // frame_end
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [ennc_pkg::OUT_W-1:0]    out_tdata,  // convex_count, concave_count, euler_value
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [ennc_pkg::CFG_W-1:0]    cfg_wdata,
  output int                            fail_count,
  output int                            tallies_pending,
  output int                            tallies_seen
);

  // lowest bits first: convex, concave, euler
  typedef struct packed {
    logic [ennc_pkg::EUL_W-1:0] euler;
    logic [ennc_pkg::CNT_W-1:0] concave;
    logic [ennc_pkg::CNT_W-1:0] convex;
  } corner_tally_t;

  logic [ennc_pkg::LABEL_W-1:0] target_label;
  logic [ennc_pkg::COLS_W-1:0]  frame_cols;
  logic                         match_line [MAX_COLS];
  logic                         ul_match;
  logic                         left_match;
  logic                         first_row;
  int unsigned                  column;
  logic [ennc_pkg::CNT_W-1:0]   convex_total;
  logic [ennc_pkg::CNT_W-1:0]   concave_total;
  corner_tally_t                tally_q [$];
  int                           failures = 0;
  int                           seen = 0;

  task automatic clear_frame();
    ul_match      = 1'b0;
    left_match    = 1'b0;
    column        = 0;
    first_row     = 1'b1;
    convex_total  = '0;
    concave_total = '0;
  endtask

  task automatic predict_pixel(input logic [ennc_pkg::LABEL_W-1:0] label,
                               input logic frame_end);
    int unsigned   row_len;
    logic          hit;
    logic          up_match;
    corner_tally_t t;
    row_len  = (frame_cols < 2) ? 2 : ((frame_cols > MAX_COLS) ? MAX_COLS : frame_cols);
    hit      = (label == target_label);
    up_match = first_row ? 1'b0 : match_line[column];
    if (hit && !first_row && column != 0 && !ul_match) begin
      if (!up_match && !left_match) begin
        if (convex_total != ennc_pkg::CNT_MAX) convex_total = convex_total + 1'b1;
      end else if (up_match && left_match) begin
        if (concave_total != ennc_pkg::CNT_MAX) concave_total = concave_total + 1'b1;
      end
    end
    ul_match           = up_match;
    left_match         = hit;
    match_line[column] = hit;
    if (column + 1 >= row_len) begin
      column    = 0;
      first_row = 1'b0;
    end else begin
      column = column + 1;
    end
    if (frame_end) begin
      t.convex  = convex_total;
      t.concave = concave_total;
      t.euler   = {1'b0, convex_total} - {1'b0, concave_total};
      tally_q.push_back(t);
      clear_frame();
    end
  endtask

  always @(posedge clk) begin : watch
    corner_tally_t got;
    corner_tally_t want;
    if (!rst_n) begin
      target_label = ennc_pkg::TARGET_RST;
      frame_cols   = ennc_pkg::COLS_RST;
      for (int i = 0; i < MAX_COLS; i++) match_line[i] = 1'b0;
      tally_q.delete();
      clear_frame();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == ennc_pkg::CFG_TARGET_LABEL) begin
          target_label = cfg_wdata[ennc_pkg::LABEL_W-1:0];
        end else if (cfg_addr == ennc_pkg::CFG_FRAME_COLS) begin
          frame_cols = cfg_wdata[ennc_pkg::COLS_W-1:0];
        end
      end
      // compare before pushing so a result never meets its own frame in one edge
      if (out_tvalid && out_tready) begin
        got  = out_tdata;
        seen = seen + 1;
        if (tally_q.size() == 0) begin
          $error("result transfer with no frame pending: %h", out_tdata);
          failures++;
        end else begin
          want = tally_q.pop_front();
          if (got.convex != want.convex) begin
            $error("convex_count: expected %0d, actual %0d", want.convex, got.convex);
            failures++;
          end
          if (got.concave != want.concave) begin
            $error("concave_count: expected %0d, actual %0d", want.concave, got.concave);
            failures++;
          end
          if (got.euler != want.euler) begin
            $error("euler_value: expected %0d, actual %0d",
                   $signed(want.euler), $signed(got.euler));
            failures++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_pixel(in_tdata, in_tlast);
    end
    fail_count      <= failures;
    tallies_pending <= tally_q.size();
    tallies_seen    <= seen;
  end

endmodule

FILE: tb/euler_number_counter_tb.sv
// testbench top for the euler number counter: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module euler_number_counter_tb;

  localparam int unsigned MAX_COLS     = 1024;
  localparam int unsigned PIXEL_BUDGET = 1750;
  localparam int          MIN_FRAMES   = 48;
  localparam int unsigned LONG_HOLD    = 500;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [ennc_pkg::LABEL_W-1:0] in_tdata;   // pixel_label
  logic                         in_tlast;   // frame_end
  logic                         out_tvalid;
  logic                         out_tready;
  logic [ennc_pkg::OUT_W-1:0]   out_tdata;  // convex_count, concave_count, euler_value
  logic                         cfg_we;
  logic                         cfg_addr;
  logic [ennc_pkg::CFG_W-1:0]   cfg_wdata;

  int          fail_count;
  int          tallies_pending;
  int          tallies_seen;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned pixels_sent = 0;
  int unsigned cycle_count = 0;

  euler_number_counter #(
    .MAX_COLS  (MAX_COLS),
    .LABEL_BITS(ennc_pkg::LABEL_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  euler_number_counter_checker #(
    .MAX_COLS(MAX_COLS)
  ) tally_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .tallies_pending(tallies_pending),
    .tallies_seen   (tallies_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic put_pixel(input logic [ennc_pkg::LABEL_W-1:0] label, input logic frame_end);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= label;
    in_tlast  <= frame_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
  endtask

  // waits until every frame result has left and the pipeline has emptied
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tallies_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [ennc_pkg::LABEL_W-1:0] target,
                            input logic [ennc_pkg::COLS_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_addr  <= ennc_pkg::CFG_TARGET_LABEL;
    cfg_wdata <= ennc_pkg::CFG_W'(target);
    @(posedge clk);
    cfg_addr  <= ennc_pkg::CFG_FRAME_COLS;
    cfg_wdata <= ennc_pkg::CFG_W'(cols);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [ennc_pkg::LABEL_W-1:0] pick_label(
    input logic [ennc_pkg::LABEL_W-1:0] target,
    input int unsigned                  hit_pct
  );
    logic [ennc_pkg::LABEL_W-1:0] lbl;
    if ($urandom_range(99) < hit_pct) return target;
    case ($urandom_range(2))
      0:       lbl = target ^ (ennc_pkg::LABEL_W'(1) << $urandom_range(ennc_pkg::LABEL_W-1));
      1:       lbl = ennc_pkg::LABEL_W'($urandom);
      default: lbl = ~target;
    endcase
    return lbl;
  endfunction

  function automatic logic [ennc_pkg::LABEL_W-1:0] pick_target();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return ennc_pkg::LABEL_W'($urandom);
    endcase
  endfunction

  // row widths visited in turn, clamped extremes among them
  function automatic logic [ennc_pkg::COLS_W-1:0] plan_cols(input int unsigned k);
    case (k % 12)
      0:       return 11'd3;
      1:       return 11'd1;
      2:       return 11'd16;
      3:       return 11'd2;
      4:       return 11'd2047;
      5:       return 11'd5;
      6:       return 11'd1024;
      7:       return 11'd8;
      8:       return 11'd1025;
      9:       return 11'd4;
      10:      return 11'd0;
      default: return 11'd32;
    endcase
  endfunction

  task automatic send_frame(input int unsigned n_pix, input int unsigned hit_pct,
                            input logic [ennc_pkg::LABEL_W-1:0] target);
    for (int unsigned i = 0; i < n_pix; i++) put_pixel(pick_label(target, hit_pct), i == n_pix - 1);
  endtask

  initial begin : stimulus
    int unsigned                  base;
    int unsigned                  done;
    int unsigned                  plan;
    int unsigned                  row_len;
    int unsigned                  n_pix;
    bit                           big_done;
    logic [ennc_pkg::COLS_W-1:0]  cols;
    logic [ennc_pkg::LABEL_W-1:0] target;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= ennc_pkg::CFG_TARGET_LABEL;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two-wide rows, target zero
    set_config('0, 11'd2);
    // lone convex corner
    put_pixel('1, 1'b0); put_pixel('1, 1'b0); put_pixel('1, 1'b0); put_pixel('0, 1'b1);
    // lone concave corner, negative euler number
    put_pixel('1, 1'b0); put_pixel('0, 1'b0); put_pixel('0, 1'b0); put_pixel('0, 1'b1);
    // frame of one pixel
    put_pixel('0, 1'b1);
    // solid block ending mid-row
    put_pixel('0, 1'b0); put_pixel('0, 1'b0); put_pixel('0, 1'b0); put_pixel('0, 1'b0);
    put_pixel('0, 1'b1);
    drain();
    // width zero behaves as two
    set_config('1, 11'd0);
    put_pixel('0, 1'b0); put_pixel('1, 1'b0); put_pixel('0, 1'b0); put_pixel('1, 1'b0);
    put_pixel('1, 1'b0); put_pixel('0, 1'b1);
    drain();

    tx_idle_pct = 13;
    rx_idle_pct = 63;
    base = pixels_sent;

    // result side held off while short frames keep coming
    target = pick_target();
    set_config(target, 11'd2);
    long_hold_req = 1'b1;
    repeat (30) send_frame($urandom_range(2, 3), 50, target);
    drain();

    plan     = 0;
    big_done = 1'b0;
    while (pixels_sent - base < PIXEL_BUDGET || tallies_seen < MIN_FRAMES) begin
      done = pixels_sent - base;
      if (done < PIXEL_BUDGET / 3) begin
        tx_idle_pct = 13;
        rx_idle_pct = 63;
      end else if (done < 2 * PIXEL_BUDGET / 3) begin
        tx_idle_pct = 63;
        rx_idle_pct = 13;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      cols = plan_cols(plan);
      plan++;
      target  = pick_target();
      row_len = (cols < 2) ? 2 : ((cols > MAX_COLS) ? MAX_COLS : cols);
      set_config(target, cols);
      repeat ($urandom_range(3, 6)) begin
        if (row_len == MAX_COLS) begin
          // one frame crosses the widest row, the rest stay in the first row
          if (cols == 11'd2047 && !big_done) begin
            n_pix    = MAX_COLS + $urandom_range(8, 24);
            big_done = 1'b1;
          end else begin
            n_pix = $urandom_range(1, 40);
          end
        end else begin
          n_pix = $urandom_range(0, 6) * row_len + $urandom_range(0, row_len - 1);
        end
        if (n_pix == 0) n_pix = 1;
        send_frame(n_pix, $urandom_range(10, 90), target);
      end
      drain();
    end

    drain();
    if (fail_count == 0 && tallies_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
